>>> src/stt_pkg.sv
// stt_pkg: shared types and codes for the software timer table.
// Used by stt_alu and the top module; depends on nothing.

package stt_pkg;

    localparam int DATA_W   = 32;
    localparam int OWNER_W  = 8;
    localparam int HANDLE_W = 4;
    localparam int CMD_W    = 3;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 8;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START_ONCE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_PERIOD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK         = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEANUP      = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STARTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_OWNER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_ENABLE   = 4'd1;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [DATA_W-1:0]   delay_ms;
        logic [DATA_W-1:0]   now_ms;
        logic [HANDLE_W-1:0] slot_handle;
        logic [OWNER_W-1:0]  owner_id;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  fired_owner;
        logic                last;
    } out_item_t;

    // one slot as held in the slot RAM
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [DATA_W-1:0]  period;
        logic [DATA_W-1:0]  due;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_READ,
        ST_EVAL,
        ST_REARM,
        ST_DONE
    } state_t;

endpackage

>>> src/stt_ram.sv
// stt_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.

module stt_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/stt_alu.sv
// stt_alu: the shared 32-bit adder/subtractor used for due-time sums and
// the wrap-safe expiry difference. Depends on stt_pkg.

module stt_alu
    import stt_pkg::*;
(
    input  logic              sub,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] y
);

    logic [DATA_W-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign y    = a + b_op + DATA_W'(sub);

endmodule

>>> src/software_timer_table_top.sv
// software_timer_table_top: table of millisecond timers with a slot scanner.
// Depends on stt_pkg, stt_ram (slot store) and stt_alu (shared adder).
//
//  channel | signals                            | transaction
//  --------+------------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_item        | one command (start/cancel/tick/cleanup)
//  out     | out_valid, out_ready, out_item     | one result; last marks end of command
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | one register write, always taken
//          | cfg_data                           |
//
// One command at a time; in_ready is high only while the sequencer is idle.
// Every command is also taken in the idle state and delivers its final result from ST_DONE.
// Start: one busy bit examined per cycle.
// Tick: a free slot takes ST_READ, a busy slot ST_READ and ST_EVAL, and a periodic slot
// that fires also ST_REARM; the single slot RAM read port sets this.
// Cleanup: free slot ST_READ, busy slot ST_READ then ST_EVAL; cancel and others: ST_DONE.
// Reset clears all busy bits and the configuration at once; no clearing pass.
// A stalled output holds the scan: the next firing slot waits until the held
// result is taken. The input side stays ready once the final result is stored.

module software_timer_table_top
    import stt_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,

    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(TIMER_SLOTS - 1);

    // sequencer state
    state_t                 state_reg, state_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [TIMER_SLOTS-1:0] busy_reg, busy_next;

    // latched command (payload, no reset)
    logic [CMD_W-1:0]       cmd_reg;
    logic [DATA_W-1:0]      delay_reg;
    logic [DATA_W-1:0]      now_reg;
    logic [OWNER_W-1:0]     owner_reg;

    // single-result response and held fired result
    logic [KIND_W-1:0]      resp_kind_reg, resp_kind_next;
    logic [HANDLE_W-1:0]    resp_handle_reg, resp_handle_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0]    pend_handle_reg, pend_handle_next;
    logic [OWNER_W-1:0]     pend_owner_reg, pend_owner_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg, out_data_next;
    logic                   out_free;
    logic                   out_push;
    out_item_t              out_push_data;

    // configuration
    logic [OWNER_W-1:0]     cur_owner_reg;
    logic                   tick_en_reg;

    // slot RAM and shared adder
    logic                   ram_we;
    logic                   ram_re;
    slot_entry_t            ram_wdata;
    slot_entry_t            ram_rdata;
    logic                   alu_sub;
    logic [DATA_W-1:0]      alu_b;
    logic [DATA_W-1:0]      alu_y;

    logic                   in_acc;
    logic                   fire;
    logic                   cancel_ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign fire      = !alu_y[DATA_W-1];
    assign cancel_ok = 32'(in_item.slot_handle) < 32'(TIMER_SLOTS);

    stt_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    stt_alu u_alu (
        .sub (alu_sub),
        .a   (now_reg),
        .b   (alu_b),
        .y   (alu_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_owner_reg  <= '0;
            tick_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CURRENT_OWNER)
                begin
                    cur_owner_reg <= cfg_data;
                end
                else if (cfg_index == REG_TICK_ENABLE)
                begin
                    tick_en_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg   <= in_item.cmd;
            delay_reg <= in_item.delay_ms;
            now_reg   <= in_item.now_ms;
            owner_reg <= in_item.owner_id;
        end
        resp_kind_reg   <= resp_kind_next;
        resp_handle_reg <= resp_handle_next;
        pend_handle_reg <= pend_handle_next;
        pend_owner_reg  <= pend_owner_next;
        out_data_reg    <= out_data_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        busy_next        = busy_reg;
        resp_kind_next   = resp_kind_reg;
        resp_handle_next = resp_handle_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_owner_next  = pend_owner_reg;
        out_push         = 1'b0;
        out_push_data    = '0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_wdata        = ram_rdata;
        alu_sub          = 1'b0;
        alu_b            = delay_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next         = '0;
                    pend_valid_next  = 1'b0;
                    resp_kind_next   = KIND_DONE;
                    resp_handle_next = '0;
                    case (in_item.cmd)
                        CMD_START_ONCE, CMD_START_PERIOD:
                        begin
                            state_next = ST_FIND;
                        end
                        CMD_CANCEL:
                        begin
                            if (cancel_ok)
                            begin
                                busy_next[SW'(in_item.slot_handle)] = 1'b0;
                            end
                            state_next = ST_DONE;
                        end
                        CMD_TICK:
                        begin
                            resp_kind_next = KIND_NONE;
                            state_next     = tick_en_reg ? ST_READ : ST_DONE;
                        end
                        CMD_CLEANUP:
                        begin
                            state_next = (in_item.owner_id != '0) ? ST_READ : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_FIND:
            begin
                // now + delay for the new due time
                if (!busy_reg[idx_reg])
                begin
                    ram_we           = 1'b1;
                    ram_wdata.owner  = cur_owner_reg;
                    ram_wdata.period = (cmd_reg == CMD_START_PERIOD) ? delay_reg : '0;
                    ram_wdata.due    = alu_y;
                    busy_next[idx_reg] = 1'b1;
                    resp_kind_next   = KIND_STARTED;
                    resp_handle_next = HANDLE_W'(idx_reg);
                    state_next       = ST_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    resp_kind_next = KIND_FULL;
                    state_next     = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_READ:
            begin
                if (busy_reg[idx_reg])
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_EVAL:
            begin
                // now - due; sign bit clear means expired
                alu_sub = 1'b1;
                alu_b   = ram_rdata.due;
                if (cmd_reg == CMD_TICK)
                begin
                    if (fire && !(pend_valid_reg && !out_free))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_push                  = 1'b1;
                            out_push_data.kind        = KIND_FIRED;
                            out_push_data.handle      = pend_handle_reg;
                            out_push_data.fired_owner = pend_owner_reg;
                            out_push_data.last        = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_handle_next = HANDLE_W'(idx_reg);
                        pend_owner_next  = ram_rdata.owner;
                        if (ram_rdata.period == '0)
                        begin
                            busy_next[idx_reg] = 1'b0;
                        end
                    end
                end
                else if (ram_rdata.owner == owner_reg)
                begin
                    busy_next[idx_reg] = 1'b0;
                end

                // advance unless stalled on the output or heading to rearm
                if (cmd_reg == CMD_TICK && fire && pend_valid_reg && !out_free)
                begin
                    state_next = ST_EVAL;
                end
                else if (cmd_reg == CMD_TICK && fire && ram_rdata.period != '0)
                begin
                    state_next = ST_REARM;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_REARM:
            begin
                alu_b         = ram_rdata.period;
                ram_we        = 1'b1;
                ram_wdata.due = alu_y;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_push = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_push_data.kind        = KIND_FIRED;
                        out_push_data.handle      = pend_handle_reg;
                        out_push_data.fired_owner = pend_owner_reg;
                    end
                    else
                    begin
                        out_push_data.kind   = resp_kind_reg;
                        out_push_data.handle = resp_handle_reg;
                    end
                    out_push_data.last = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_push)
        begin
            out_valid_next = 1'b1;
            out_data_next  = out_push_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // a held fired result only exists during a tick
    a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (cmd_reg == CMD_TICK))
        else $error("fired result held outside a tick");

    // the final result is stored and the sequencer goes idle together
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (state_reg == ST_IDLE && out_valid_reg
                                               && out_data_reg.last))
        else $error("final result not delivered on completion");

    // only fired results may leave with last low
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.kind != KIND_FIRED) |-> out_data_reg.last)
        else $error("non-fired result without last");

    // the scan never pushes while the output register is still occupied
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> out_free)
        else $error("output register overwritten");

    // a rearm only follows an evaluation
    a_rearm_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REARM) |-> ($past(state_reg) == ST_EVAL))
        else $error("rearm without evaluation");

endmodule
